// File: hw/rtl/vna_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_pkg
// Shared constants, codes, state types and helpers of the vertex normal
// accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int VERTEX_COUNT = 4096;
   localparam int COORD_BITS   = 16;
   localparam int SUM_BITS     = 48;

   localparam int ADDR_BITS    = $clog2(VERTEX_COUNT);
   localparam int INDEX_BITS   = 12;
   localparam int FIELD_BITS   = 16;
   localparam int UNIT_BITS    = 16;

   localparam int POS_BITS     = 3 * COORD_BITS;
   localparam int SUMS_BITS    = 3 * SUM_BITS;
   localparam int EDGE_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * EDGE_BITS;
   localparam int CROSS_BITS   = PROD_BITS + 1;
   localparam int ADD_BITS     = ((SUM_BITS > CROSS_BITS) ? SUM_BITS : CROSS_BITS) + 1;

   localparam int NORM_TOP     = 29;
   localparam int MAG_BITS     = NORM_TOP + 1;
   localparam int SQ_BITS      = 2 * MAG_BITS;
   localparam int LEN2_BITS    = SQ_BITS + 2;
   localparam int ROOT_BITS    = MAG_BITS + 1;
   localparam int FRAC_SHIFT   = 14;
   localparam int QUOT_BITS    = 16;
   localparam int QSTEP_BITS   = $clog2(QUOT_BITS);
   localparam int DIV_BITS     = ROOT_BITS + QUOT_BITS - 1;

   localparam logic [UNIT_BITS-1:0] UNIT_ONE = 16'd16384;

   localparam logic signed [24:0] COORD_HI =
      25'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [24:0] COORD_LO = -COORD_HI - 25'sd1;

   localparam logic signed [ADD_BITS-1:0] SUM_HI =
      ADD_BITS'((65'sd1 <<< (SUM_BITS - 1)) - 65'sd1);
   localparam logic signed [ADD_BITS-1:0] SUM_LO = -SUM_HI - ADD_BITS'(1);

   // operation codes
   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_TRIANGLE = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TRI_A,
      ST_TRI_B,
      ST_TRI_C,
      ST_TRI_EDGE,
      ST_TRI_MUL,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_RD_SUM,
      ST_RD_START,
      ST_RD_WAIT,
      ST_RD_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_CHECK,
      N_SHIFT,
      N_SQUARE,
      N_ROOT,
      N_DIV_INIT,
      N_DIV_STEP,
      N_DONE
   } norm_state_type;

   typedef struct packed {
      logic                        degenerate;
      logic [2:0][UNIT_BITS-1:0]   comp;
   } normal_type;

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(
      input logic [FIELD_BITS-1:0] raw
   );
      logic signed [24:0] wide;
      wide = 25'($signed(raw));
      if (wide > COORD_HI) begin
         wide = COORD_HI;
      end else if (wide < COORD_LO) begin
         wide = COORD_LO;
      end
      return COORD_BITS'(wide);
   endfunction

   function automatic logic in_range(input logic [INDEX_BITS-1:0] idx);
      return 32'(idx) < 32'(VERTEX_COUNT);
   endfunction

   function automatic logic [ADDR_BITS-1:0] to_addr(input logic [INDEX_BITS-1:0] idx);
      return ADDR_BITS'(idx);
   endfunction

endpackage

// File: hw/rtl/vna_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/vna_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_norm
// Iterative unit normaliser: magnitude alignment, sum of squares, bit-serial
// square root and restoring division for each component.
// ----------------------------------------------------------------------------
module vna_norm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vna_pkg::SUMS_BITS-1:0] sums,
   output logic                        done,
   output vna_pkg::normal_type         result
);
   import vna_pkg::*;

   norm_state_type state_ff, state_in;

   logic [2:0][SUM_BITS-1:0]  mag_ff;
   logic [2:0]                neg_ff;
   logic [1:0]                sq_step_ff;
   logic [SQ_BITS-1:0]        sq_ff;
   logic [LEN2_BITS-1:0]      len2_ff;
   logic [LEN2_BITS-1:0]      rad_ff;
   logic [LEN2_BITS-1:0]      root_ff;
   logic [LEN2_BITS-1:0]      bit_ff;
   logic [1:0]                comp_ff;
   logic [QSTEP_BITS-1:0]     qstep_ff;
   logic [DIV_BITS-1:0]       rem_ff;
   logic [DIV_BITS-1:0]       dsh_ff;
   logic [QUOT_BITS-1:0]      quot_ff;
   normal_type                res_ff;

   logic                      any_above;
   logic                      any_top;
   logic                      all_zero;
   logic [LEN2_BITS-1:0]      trial;
   logic                      root_ge;
   logic                      div_ge;
   logic [QUOT_BITS-1:0]      quot_next;
   logic [UNIT_BITS-1:0]      q_clamped;
   logic [ROOT_BITS-1:0]      len;

   always_comb begin
      any_above = 1'b0;
      any_top   = 1'b0;
      all_zero  = 1'b1;
      for (int k = 0; k < 3; k++) begin
         any_above = any_above | (|(mag_ff[k] >> (NORM_TOP + 1)));
         any_top   = any_top | mag_ff[k][NORM_TOP];
         all_zero  = all_zero & (mag_ff[k] == '0);
      end
   end

   assign trial     = root_ff + bit_ff;
   assign root_ge   = rad_ff >= trial;
   assign len       = root_ff[ROOT_BITS-1:0];
   assign div_ge    = rem_ff >= dsh_ff;
   assign quot_next = {quot_ff[QUOT_BITS-2:0], div_ge};
   assign q_clamped = (UNIT_BITS'(quot_next) > UNIT_ONE) ? UNIT_ONE : UNIT_BITS'(quot_next);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         N_IDLE:     if (start) state_in = N_CHECK;
         N_CHECK:    state_in = all_zero ? N_DONE : N_SHIFT;
         N_SHIFT:    if (!any_above && any_top) state_in = N_SQUARE;
         N_SQUARE:   if (sq_step_ff == 2'd3) state_in = N_ROOT;
         N_ROOT:     if (bit_ff[0]) state_in = N_DIV_INIT;
         N_DIV_INIT: state_in = N_DIV_STEP;
         N_DIV_STEP: begin
            if (qstep_ff == QSTEP_BITS'(QUOT_BITS - 1)) begin
               state_in = (comp_ff == 2'd2) ? N_DONE : N_DIV_INIT;
            end
         end
         N_DONE:     state_in = N_IDLE;
         default:    state_in = N_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done   = (state_ff == N_DONE);
      result = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end

      unique case (state_ff)
         N_IDLE: begin
            for (int k = 0; k < 3; k++) begin
               neg_ff[k] <= sums[k*SUM_BITS + SUM_BITS - 1];
               mag_ff[k] <= sums[k*SUM_BITS + SUM_BITS - 1]
                            ? (SUM_BITS'(0) - sums[k*SUM_BITS +: SUM_BITS])
                            : sums[k*SUM_BITS +: SUM_BITS];
            end
         end
         N_CHECK: begin
            res_ff.degenerate <= all_zero;
            res_ff.comp       <= '0;
         end
         N_SHIFT: begin
            // align the largest magnitude to the top bit position
            if (any_above) begin
               for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] >> 1;
            end else if (!any_top) begin
               for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] << 1;
            end
            sq_step_ff <= '0;
            len2_ff    <= '0;
         end
         N_SQUARE: begin
            if (sq_step_ff != 2'd3) begin
               sq_ff  <= SQ_BITS'(mag_ff[0][MAG_BITS-1:0]) * SQ_BITS'(mag_ff[0][MAG_BITS-1:0]);
               mag_ff <= {mag_ff[0], mag_ff[2:1]};
            end
            if (sq_step_ff != 2'd0) begin
               len2_ff <= len2_ff + LEN2_BITS'(sq_ff);
            end
            sq_step_ff <= sq_step_ff + 2'd1;
            rad_ff     <= len2_ff + LEN2_BITS'(sq_ff);
            root_ff    <= '0;
            bit_ff     <= LEN2_BITS'(1) << (LEN2_BITS - 2);
         end
         N_ROOT: begin
            if (root_ge) begin
               rad_ff  <= rad_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            comp_ff <= '0;
         end
         N_DIV_INIT: begin
            rem_ff   <= DIV_BITS'({mag_ff[0][MAG_BITS-1:0], FRAC_SHIFT'(0)}) +
                        DIV_BITS'(len >> 1);
            dsh_ff   <= DIV_BITS'(len) << (QUOT_BITS - 1);
            quot_ff  <= '0;
            qstep_ff <= '0;
         end
         N_DIV_STEP: begin
            if (div_ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            dsh_ff   <= dsh_ff >> 1;
            quot_ff  <= quot_next;
            qstep_ff <= qstep_ff + QSTEP_BITS'(1);
            if (qstep_ff == QSTEP_BITS'(QUOT_BITS - 1)) begin
               // components enter at the top and move down
               res_ff.comp[2] <= neg_ff[0] ? (UNIT_BITS'(0) - q_clamped) : q_clamped;
               res_ff.comp[1] <= res_ff.comp[2];
               res_ff.comp[0] <= res_ff.comp[1];
               mag_ff  <= {mag_ff[0], mag_ff[2:1]};
               neg_ff  <= {neg_ff[0], neg_ff[2:1]};
               comp_ff <= comp_ff + 2'd1;
            end
         end
         N_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hw/rtl/vertex_normal_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted vertex normals: position table, per-vertex normal sums and a
// unit-length read-out.
// ----------------------------------------------------------------------------
// After reset the block sweeps the normal-sum memory to zero, one entry per
// cycle over all VERTEX_COUNT entries (4096 here), and takes no item
// meanwhile. One item is handled at a time. A load is a single write to both
// memories. A triangle takes three position reads through the one read port,
// seven steps of the shared edge multiplier and a read-modify-write of the
// sum memory for each corner. A read of a nonzero sum goes through the
// normaliser: alignment shifts one bit a cycle, then squaring, 31
// square-root steps and 3 x 17 division steps; a read of a zero sum skips
// these. A read also waits while an earlier result is still held. The
// result waits in an output register, so further loads and triangles are
// taken while it is pending.
module vertex_normal_accumulator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_index, second_index, third_index, pos_x, pos_y, pos_z, 4 zero bits
   input  logic [87:0] req_tdata,
   // operation
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // vertex_echo, normal_x, normal_y, normal_z, 4 zero bits
   output logic [63:0] rsp_tdata,
   // degenerate
   output logic [0:0]  rsp_tuser
);
   import vna_pkg::*;

   top_state_type state_ff, state_in;

   logic [INDEX_BITS-1:0] first_index, second_index, third_index;
   logic [FIELD_BITS-1:0] pos_x, pos_y, pos_z;
   logic                  accept;

   logic [ADDR_BITS-1:0]  clear_cnt_ff;
   logic [ADDR_BITS-1:0]  idx_ff [3];
   logic [INDEX_BITS-1:0] echo_ff;
   logic [POS_BITS-1:0]   pa_ff, pb_ff;
   logic signed [EDGE_BITS-1:0]  e1_ff [3];
   logic signed [EDGE_BITS-1:0]  e2_ff [3];
   logic [2:0]            step_ff;
   logic signed [PROD_BITS-1:0]  prod_ff, first_ff;
   logic signed [CROSS_BITS-1:0] cross_ff [3];
   logic [1:0]            corner_ff;
   normal_type            res_ff;
   logic                  rsp_valid_ff;
   logic [63:0]           rsp_data_ff;
   logic                  rsp_user_ff;

   logic                  pos_we, sum_we;
   logic [ADDR_BITS-1:0]  pos_waddr, pos_raddr, sum_waddr, sum_raddr;
   logic [POS_BITS-1:0]   pos_wdata, pos_rdata;
   logic [SUMS_BITS-1:0]  sum_wdata, sum_rdata, sum_acc;
   logic                  norm_start, norm_done, rsp_load;
   normal_type            norm_res;
   logic signed [EDGE_BITS-1:0]  op_a, op_b;
   logic signed [PROD_BITS-1:0]  mul;
   logic                  tri_ok;

   assign first_index  = req_tdata[11:0];
   assign second_index = req_tdata[23:12];
   assign third_index  = req_tdata[35:24];
   assign pos_x        = req_tdata[51:36];
   assign pos_y        = req_tdata[67:52];
   assign pos_z        = req_tdata[83:68];
   assign accept       = req_tvalid && req_tready;
   assign tri_ok       = in_range(first_index) && in_range(second_index) &&
                         in_range(third_index);

   function automatic logic signed [COORD_BITS-1:0] coord(
      input logic [POS_BITS-1:0] pos, input int k
   );
      return $signed(pos[k*COORD_BITS +: COORD_BITS]);
   endfunction

   vna_ram #(.WIDTH(POS_BITS), .DEPTH(VERTEX_COUNT)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (pos_wdata),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   vna_ram #(.WIDTH(SUMS_BITS), .DEPTH(VERTEX_COUNT)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr),
      .wr_data (sum_wdata),
      .rd_addr (sum_raddr),
      .rd_data (sum_rdata)
   );

   vna_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .sums   (sum_rdata),
      .done   (norm_done),
      .result (norm_res)
   );

   // shared multiplier operands for the cross product
   always_comb begin
      case (step_ff)
         3'd0:    begin op_a = e1_ff[1]; op_b = e2_ff[2]; end
         3'd1:    begin op_a = e1_ff[2]; op_b = e2_ff[1]; end
         3'd2:    begin op_a = e1_ff[2]; op_b = e2_ff[0]; end
         3'd3:    begin op_a = e1_ff[0]; op_b = e2_ff[2]; end
         3'd4:    begin op_a = e1_ff[0]; op_b = e2_ff[1]; end
         default: begin op_a = e1_ff[1]; op_b = e2_ff[0]; end
      endcase
      mul = PROD_BITS'(op_a) * PROD_BITS'(op_b);
   end

   // saturating accumulate of the cross product
   always_comb begin
      logic signed [ADD_BITS-1:0] acc;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         acc = ADD_BITS'($signed(sum_rdata[k*SUM_BITS +: SUM_BITS])) +
               ADD_BITS'(cross_ff[k]);
         if (acc > SUM_HI) begin
            acc = SUM_HI;
         end else if (acc < SUM_LO) begin
            acc = SUM_LO;
         end
         sum_acc[k*SUM_BITS +: SUM_BITS] = SUM_BITS'(acc);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_cnt_ff == ADDR_BITS'(VERTEX_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_TRIANGLE: if (tri_ok) state_in = ST_TRI_A;
                  OP_READ:     state_in = in_range(first_index) ? ST_RD_SUM : ST_RD_OUT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_TRI_A:    state_in = ST_TRI_B;
         ST_TRI_B:    state_in = ST_TRI_C;
         ST_TRI_C:    state_in = ST_TRI_EDGE;
         ST_TRI_EDGE: state_in = ST_TRI_MUL;
         ST_TRI_MUL:  if (step_ff == 3'd6) state_in = ST_ACC_RD;
         ST_ACC_RD:   state_in = ST_ACC_WR;
         ST_ACC_WR:   state_in = (corner_ff == 2'd2) ? ST_IDLE : ST_ACC_RD;
         ST_RD_SUM:   state_in = ST_RD_START;
         ST_RD_START: state_in = ST_RD_WAIT;
         ST_RD_WAIT:  if (norm_done) state_in = ST_RD_OUT;
         ST_RD_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      pos_we     = 1'b0;
      pos_waddr  = to_addr(first_index);
      pos_wdata  = {clamp_coord(pos_z), clamp_coord(pos_y), clamp_coord(pos_x)};
      pos_raddr  = idx_ff[0];
      sum_we     = 1'b0;
      sum_waddr  = idx_ff[corner_ff];
      sum_wdata  = sum_acc;
      sum_raddr  = idx_ff[corner_ff];
      norm_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            sum_we    = 1'b1;
            sum_waddr = clear_cnt_ff;
            sum_wdata = '0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && req_tuser == OP_LOAD && in_range(first_index)) begin
               pos_we    = 1'b1;
               sum_we    = 1'b1;
               sum_waddr = to_addr(first_index);
               sum_wdata = '0;
            end
         end
         ST_TRI_A:    pos_raddr = idx_ff[0];
         ST_TRI_B:    pos_raddr = idx_ff[1];
         ST_TRI_C:    pos_raddr = idx_ff[2];
         ST_ACC_WR:   sum_we = 1'b1;
         ST_RD_SUM:   sum_raddr = idx_ff[0];
         ST_RD_START: norm_start = 1'b1;
         ST_RD_OUT:   rsp_load = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clear_cnt_ff <= clear_cnt_ff + ADDR_BITS'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (rsp_load) begin
         rsp_data_ff <= {4'b0, res_ff.comp[2], res_ff.comp[1], res_ff.comp[0], echo_ff};
         rsp_user_ff <= res_ff.degenerate;
      end

      unique case (state_ff)
         ST_IDLE: begin
            idx_ff[0] <= to_addr(first_index);
            idx_ff[1] <= to_addr(second_index);
            idx_ff[2] <= to_addr(third_index);
            echo_ff   <= first_index;
            res_ff    <= '{degenerate: 1'b1, comp: '0};
         end
         ST_TRI_B: pa_ff <= pos_rdata;
         ST_TRI_C: pb_ff <= pos_rdata;
         ST_TRI_EDGE: begin
            for (int k = 0; k < 3; k++) begin
               e1_ff[k] <= EDGE_BITS'(coord(pos_rdata, k)) - EDGE_BITS'(coord(pa_ff, k));
               e2_ff[k] <= EDGE_BITS'(coord(pb_ff, k)) - EDGE_BITS'(coord(pa_ff, k));
            end
            step_ff <= '0;
         end
         ST_TRI_MUL: begin
            prod_ff <= mul;
            // odd steps hold the first product, even steps form a component
            if (step_ff[0]) begin
               first_ff <= prod_ff;
            end else if (step_ff != 3'd0) begin
               cross_ff[2'(step_ff >> 1) - 2'd1] <=
                  CROSS_BITS'(first_ff) - CROSS_BITS'(prod_ff);
            end
            step_ff   <= step_ff + 3'd1;
            corner_ff <= '0;
         end
         ST_ACC_WR:  corner_ff <= corner_ff + 2'd1;
         ST_RD_WAIT: if (norm_done) res_ff <= norm_res;
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: hw/rtl/vna_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_checker
// Port-level checks of the vertex normal accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module vna_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // reset empties the output and starts the clearing sweep
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("output or input open after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // degenerate flag and zero normal go together
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[59:12] == 48'd0)
      else $error("degenerate result with nonzero normal");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[59:12] != 48'd0)
      else $error("unit normal is zero");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vertex normal accumulator: directed and random
// loads, triangles and reads go through the request stream. Each accepted
// transfer updates a local model of the position table and normal sums, and
// read results are checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
   import vna_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic [11:0]        i0, i1, i2;
      logic signed [15:0] px, py, pz;
      bit                 drain;
   } mesh_cmd_t;

   typedef struct {
      logic [11:0] echo;
      logic [15:0] nx, ny, nz;
      logic        degen;
   } normal_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   mesh_cmd_t   cmd_q[$];
   normal_rsp_t normal_q[$];
   mesh_cmd_t   cur_cmd;
   bit          cmd_taken = 0;
   int          n_items = 0;
   int          n_sent = 0;
   int          n_recv = 0;
   int          n_errors = 0;

   // local copy of the block state
   logic signed [15:0] pos_x_tab[VERTEX_COUNT];
   logic signed [15:0] pos_y_tab[VERTEX_COUNT];
   logic signed [15:0] pos_z_tab[VERTEX_COUNT];
   longint             acc_x[VERTEX_COUNT];
   longint             acc_y[VERTEX_COUNT];
   longint             acc_z[VERTEX_COUNT];

   // generator-side record of loaded vertices
   bit loaded[VERTEX_COUNT];
   int loaded_list[$];

   vertex_normal_accumulator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic longint sat_sum(input longint a, input longint b);
      longint s, hi;
      hi = (64'sd1 <<< (SUM_BITS - 1)) - 1;
      s  = a + b;
      if (s > hi) s = hi;
      if (s < -hi - 1) s = -hi - 1;
      return s;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic normal_rsp_t unit_normal(input int v);
      normal_rsp_t      r;
      longint           s[3];
      longint unsigned  m[3], big, len2, len, q;
      int               t;
      s[0] = acc_x[v]; s[1] = acc_y[v]; s[2] = acc_z[v];
      r.echo = 12'(v);
      r.nx = '0; r.ny = '0; r.nz = '0;
      for (int k = 0; k < 3; k++) m[k] = (s[k] < 0) ? -s[k] : s[k];
      big = m[0];
      if (m[1] > big) big = m[1];
      if (m[2] > big) big = m[2];
      r.degen = (big == 0);
      if (big == 0) return r;
      t = 63;
      while (big[t] == 1'b0) t--;
      for (int k = 0; k < 3; k++)
         m[k] = (t > NORM_TOP) ? (m[k] >> (t - NORM_TOP)) : (m[k] << (NORM_TOP - t));
      len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len  = int_root(len2);
      for (int k = 0; k < 3; k++) begin
         q = (m[k] * 16384 + (len >> 1)) / len;
         if (q > 16384) q = 16384;
         m[k] = (s[k] < 0) ? -q : q;
      end
      r.nx = m[0][15:0]; r.ny = m[1][15:0]; r.nz = m[2][15:0];
      return r;
   endfunction

   task automatic apply_cmd(input mesh_cmd_t c);
      longint e1[3], e2[3], n[3];
      int     corner[3];
      case (c.op)
         OP_LOAD: begin
            pos_x_tab[c.i0] = c.px;
            pos_y_tab[c.i0] = c.py;
            pos_z_tab[c.i0] = c.pz;
            acc_x[c.i0] = 0; acc_y[c.i0] = 0; acc_z[c.i0] = 0;
         end
         OP_TRIANGLE: begin
            // edges taken as (third - first) and (second - first)
            e1[0] = longint'(pos_x_tab[c.i2]) - pos_x_tab[c.i0];
            e1[1] = longint'(pos_y_tab[c.i2]) - pos_y_tab[c.i0];
            e1[2] = longint'(pos_z_tab[c.i2]) - pos_z_tab[c.i0];
            e2[0] = longint'(pos_x_tab[c.i1]) - pos_x_tab[c.i0];
            e2[1] = longint'(pos_y_tab[c.i1]) - pos_y_tab[c.i0];
            e2[2] = longint'(pos_z_tab[c.i1]) - pos_z_tab[c.i0];
            n[0] = e1[1] * e2[2] - e1[2] * e2[1];
            n[1] = e1[2] * e2[0] - e1[0] * e2[2];
            n[2] = e1[0] * e2[1] - e1[1] * e2[0];
            corner[0] = c.i0; corner[1] = c.i1; corner[2] = c.i2;
            for (int k = 0; k < 3; k++) begin
               acc_x[corner[k]] = sat_sum(acc_x[corner[k]], n[0]);
               acc_y[corner[k]] = sat_sum(acc_y[corner[k]], n[1]);
               acc_z[corner[k]] = sat_sum(acc_z[corner[k]], n[2]);
            end
         end
         OP_READ: normal_q = {normal_q, unit_normal(c.i0)};
         default: ;
      endcase
   endtask

   task automatic add_cmd(input logic [1:0] op, input int a, input int b, input int c,
                          input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z, input bit drain);
      mesh_cmd_t m;
      m.op = op; m.i0 = 12'(a); m.i1 = 12'(b); m.i2 = 12'(c);
      m.px = x; m.py = y; m.pz = z; m.drain = drain;
      if (op == OP_LOAD && !loaded[a]) begin
         loaded[a] = 1;
         loaded_list = {loaded_list, a};
      end
      cmd_q = {cmd_q, m};
   endtask

   function automatic logic signed [15:0] rand_coord();
      if ($urandom_range(3) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(2047)) - 1024);
   endfunction

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   // request driver
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         apply_cmd(cur_cmd);
         cmd_taken = 1;
         n_sent++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || cmd_taken) begin
         cmd_taken = 0;
         if (cmd_q.size() > 0 && !(cmd_q[0].drain && normal_q.size() > 0) &&
             ((n_sent > 300 && n_sent < 420) || $urandom_range(99) >= 13)) begin
            cur_cmd = cmd_q.pop_front();
            req_tdata  <= {4'b0, cur_cmd.pz, cur_cmd.py, cur_cmd.px,
                           cur_cmd.i2, cur_cmd.i1, cur_cmd.i0};
            req_tuser  <= cur_cmd.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(negedge clock) begin
      rsp_tready <= (n_recv > 120 && n_recv < 170) || $urandom_range(99) >= 13;
   end

   always @(posedge clock) begin
      normal_rsp_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_recv++;
         if (normal_q.size() == 0) begin
            $error("unexpected result transfer, vertex %0d", rsp_tdata[11:0]);
            n_errors++;
         end else begin
            e = normal_q.pop_front();
            if (rsp_tdata[11:0] !== e.echo) begin
               $error("vertex_echo expected %0d actual %0d", e.echo, rsp_tdata[11:0]);
               n_errors++;
            end
            if (rsp_tdata[27:12] !== e.nx) begin
               $error("normal_x expected %0d actual %0d",
                      $signed(e.nx), $signed(rsp_tdata[27:12]));
               n_errors++;
            end
            if (rsp_tdata[43:28] !== e.ny) begin
               $error("normal_y expected %0d actual %0d",
                      $signed(e.ny), $signed(rsp_tdata[43:28]));
               n_errors++;
            end
            if (rsp_tdata[59:44] !== e.nz) begin
               $error("normal_z expected %0d actual %0d",
                      $signed(e.nz), $signed(rsp_tdata[59:44]));
               n_errors++;
            end
            if (rsp_tuser[0] !== e.degen) begin
               $error("degenerate expected %0d actual %0d", e.degen, rsp_tuser[0]);
               n_errors++;
            end
         end
      end
   end

   initial begin
      #8000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int r, a, b, c;
      for (int v = 0; v < VERTEX_COUNT; v++) begin
         pos_x_tab[v] = 0; pos_y_tab[v] = 0; pos_z_tab[v] = 0;
         acc_x[v] = 0; acc_y[v] = 0; acc_z[v] = 0;
         loaded[v] = 0;
      end

      // directed: extreme coordinates and indices, repeated corners, flat triangle
      add_cmd(OP_LOAD, 0, 4095, 4095, 16'sh8000, 16'sh8000, 16'sh8000, 0);
      add_cmd(OP_LOAD, 1, 0, 0, 16'sh7fff, 16'sh8000, 16'sh0000, 0);
      add_cmd(OP_LOAD, 2, 0, 0, 16'sh8000, 16'sh7fff, 16'sh7fff, 0);
      add_cmd(OP_LOAD, 4095, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      add_cmd(OP_LOAD, 3, 0, 0, 16'sh0100, 16'sh0000, 16'sh0000, 0);
      add_cmd(OP_LOAD, 4, 0, 0, 16'sh0000, 16'sh0100, 16'sh0000, 0);
      add_cmd(OP_LOAD, 5, 0, 0, 16'sh0200, 16'sh0000, 16'sh0000, 0);
      add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_TRIANGLE, 0, 1, 2, 0, 0, 0, 0);
      add_cmd(OP_TRIANGLE, 4095, 1, 2, 0, 0, 0, 0);
      add_cmd(OP_TRIANGLE, 0, 0, 1, 0, 0, 0, 0);
      add_cmd(OP_TRIANGLE, 0, 3, 4, 0, 0, 0, 0);
      add_cmd(OP_TRIANGLE, 0, 3, 5, 0, 0, 0, 0);
      add_cmd(OP_READ, 0, 4095, 4095, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      add_cmd(OP_READ, 1, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_READ, 2, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_READ, 4095, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_READ, 5, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_READ, 100, 0, 0, 0, 0, 0, 0);
      add_cmd(2'd3, 4095, 4095, 4095, 16'shffff, 16'shffff, 16'shffff, 0);
      add_cmd(OP_LOAD, 0, 0, 0, 16'sh0000, 16'sh0000, 16'sh0000, 1);
      add_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0);

      // random: mostly well-formed meshes over a small vertex pool
      for (int n = 0; n < 650; n++) begin
         r = $urandom_range(99);
         a = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(63);
         if (r < 30) begin
            add_cmd(OP_LOAD, a, $urandom_range(4095), $urandom_range(4095),
                    rand_coord(), rand_coord(), rand_coord(), n == 200);
         end else if (r < 70) begin
            a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
            add_cmd(OP_TRIANGLE, a, b, c, 16'($urandom), 16'($urandom), 16'($urandom),
                    n == 200);
         end else if (r < 95) begin
            if ($urandom_range(1)) a = pick_loaded();
            add_cmd(OP_READ, a, $urandom_range(4095), $urandom_range(4095),
                    16'($urandom), 16'($urandom), 16'($urandom), n == 200);
         end else begin
            add_cmd(2'd3, a, $urandom_range(4095), $urandom_range(4095),
                    16'($urandom), 16'($urandom), 16'($urandom), n == 200);
         end
      end
      n_items = cmd_q.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (n_sent == n_items);
      wait (normal_q.size() == 0);
      repeat (300) @(posedge clock);
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
